### sv/host_mcu_mailbox_ports_defines.svh
// Assertion helpers for the mailbox block.
`ifndef HOST_MCU_MAILBOX_PORTS_DEFINES_SVH
`define HOST_MCU_MAILBOX_PORTS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mailbox assertion failed");

// Next-cycle implication, checked outside reset.
`define MBX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mailbox assertion failed");

`endif

### sv/mbx_pkg.sv
`default_nettype none
package mbx_pkg;

    typedef enum logic [3:0] {
        OP_HOST_WR  = 4'd0,
        OP_HOST_RD  = 4'd1,
        OP_A_RD     = 4'd2,
        OP_A_WR     = 4'd3,
        OP_DDRA_WR  = 4'd4,
        OP_C_RD     = 4'd5,
        OP_C_WR     = 4'd6,
        OP_DDRC_WR  = 4'd7,
        OP_IN0_RD   = 4'd8
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] write_byte;
        logic [5:0] switch_bits;
    } t_req;

    // Port C handshake lines
    localparam logic [7:0] C_HOST_ACK    = 8'h04;  // falling edge pulls host byte into A
    localparam logic [7:0] C_MCU_STROBE  = 8'h08;  // falling edge posts A out to host
    // Status bits
    localparam logic [7:0] ST_HOST_PEND  = 8'h01;
    localparam logic [7:0] ST_MCU_EMPTY  = 8'h02;
    localparam logic [7:0] IN0_SW_MASK   = 8'h3f;
    localparam logic [7:0] IN0_HOST_IDLE = 8'h40;
    localparam logic [7:0] IN0_MCU_EMPTY = 8'h80;

endpackage
`default_nettype wire

### sv/host_mcu_mailbox_ports.sv
// Host/MCU byte mailbox with MCU port A, port C and their direction registers.
// Input channel: one bus transaction per item (i_operation, i_write_byte,
// i_switch_bits), taken on a rising edge with i_valid high and o_stall low.
// Output channel: one o_read_byte per transaction, taken on a rising edge with
// o_valid high and i_stall low; writes and unused codes return zero.
// Path: an accepted transaction is captured in the input register; once the
// output register is free it updates the mailbox state and its result lands in
// the output register, which raises o_valid.
// Throughput: one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds; the input register
// still fills, and o_stall rises only while both registers are occupied.
// Reset (synchronous, active low) empties both registers and clears all
// flags, latches, port and direction registers to zero.
`default_nettype none
`include "host_mcu_mailbox_ports_defines.svh"
module host_mcu_mailbox_ports
    import mbx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [3:0] i_operation,
    input  wire logic [7:0] i_write_byte,
    input  wire logic [5:0] i_switch_bits,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_byte
);

    logic       r_in_valid;
    t_req       r_req;
    logic       r_out_valid;
    logic [7:0] r_read_byte;
    logic [7:0] core_read_byte;
    logic       out_free;
    logic       advance;
    logic       in_take;
    logic       req_is_write;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign req_is_write = (r_req.op == OP_HOST_WR) || (r_req.op == OP_C_WR);

    mbx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_req       (r_req),
        .o_read_byte (core_read_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.op          <= t_op'(i_operation);
            r_req.write_byte  <= i_write_byte;
            r_req.switch_bits <= i_switch_bits;
        end
        if (advance) begin
            r_read_byte <= core_read_byte;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_read_byte;

    `MBX_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)
    `MBX_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, advance, o_valid)
    `MBX_ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n, advance && req_is_write, o_read_byte == 8'h00)

endmodule
`default_nettype wire

### sv/mbx_core.sv
`default_nettype none
module mbx_core
    import mbx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire t_req       i_req,
    output logic [7:0]      o_read_byte
);

    logic       r_host_pending, n_host_pending;
    logic [7:0] r_host_byte,    n_host_byte;
    logic       r_mcu_pending,  n_mcu_pending;
    logic [7:0] r_mcu_byte,     n_mcu_byte;
    logic [7:0] r_a_in_latch,   n_a_in_latch;
    logic [7:0] r_a_out,        n_a_out;
    logic [7:0] r_a_dir,        n_a_dir;
    logic [7:0] r_c_out,        n_c_out;
    logic [7:0] r_c_dir,        n_c_dir;

    logic [7:0] status;
    logic       fall_ack;
    logic       fall_strobe;

    always_comb begin
        status = 8'h00;
        if (r_host_pending) status = status | ST_HOST_PEND;
        if (!r_mcu_pending) status = status | ST_MCU_EMPTY;

        // edge only counts on a line driven as output
        fall_ack    = ((r_c_dir & C_HOST_ACK) != 8'h00) && ((r_c_out & C_HOST_ACK) != 8'h00)
                      && ((i_req.write_byte & C_HOST_ACK) == 8'h00);
        fall_strobe = ((r_c_dir & C_MCU_STROBE) != 8'h00)
                      && ((r_c_out & C_MCU_STROBE) != 8'h00)
                      && ((i_req.write_byte & C_MCU_STROBE) == 8'h00);

        n_host_pending = r_host_pending;
        n_host_byte    = r_host_byte;
        n_mcu_pending  = r_mcu_pending;
        n_mcu_byte     = r_mcu_byte;
        n_a_in_latch   = r_a_in_latch;
        n_a_out        = r_a_out;
        n_a_dir        = r_a_dir;
        n_c_out        = r_c_out;
        n_c_dir        = r_c_dir;
        o_read_byte    = 8'h00;

        case (i_req.op)
            OP_HOST_WR: begin
                n_host_pending = 1'b1;
                n_host_byte    = i_req.write_byte;
            end
            OP_HOST_RD: begin
                n_mcu_pending = 1'b0;
                o_read_byte   = r_mcu_byte;
            end
            OP_A_RD: begin
                o_read_byte = (r_a_out & r_a_dir) | (r_a_in_latch & ~r_a_dir);
            end
            OP_A_WR: begin
                n_a_out = i_req.write_byte;
            end
            OP_DDRA_WR: begin
                n_a_dir = i_req.write_byte;
            end
            OP_C_RD: begin
                o_read_byte = (r_c_out & r_c_dir) | (status & ~r_c_dir);
            end
            OP_C_WR: begin
                if (fall_ack) begin
                    n_host_pending = 1'b0;
                    n_a_in_latch   = r_host_byte;
                end
                if (fall_strobe) begin
                    n_mcu_pending = 1'b1;
                    n_mcu_byte    = r_a_out;
                end
                n_c_out = i_req.write_byte;
            end
            OP_DDRC_WR: begin
                n_c_dir = i_req.write_byte;
            end
            OP_IN0_RD: begin
                o_read_byte = {2'b00, i_req.switch_bits} & IN0_SW_MASK;
                if (!r_host_pending) o_read_byte = o_read_byte | IN0_HOST_IDLE;
                if (!r_mcu_pending)  o_read_byte = o_read_byte | IN0_MCU_EMPTY;
            end
            default: begin
                o_read_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_pending <= 1'b0;
            r_host_byte    <= 8'h00;
            r_mcu_pending  <= 1'b0;
            r_mcu_byte     <= 8'h00;
            r_a_in_latch   <= 8'h00;
            r_a_out        <= 8'h00;
            r_a_dir        <= 8'h00;
            r_c_out        <= 8'h00;
            r_c_dir        <= 8'h00;
        end else if (i_en) begin
            r_host_pending <= n_host_pending;
            r_host_byte    <= n_host_byte;
            r_mcu_pending  <= n_mcu_pending;
            r_mcu_byte     <= n_mcu_byte;
            r_a_in_latch   <= n_a_in_latch;
            r_a_out        <= n_a_out;
            r_a_dir        <= n_a_dir;
            r_c_out        <= n_c_out;
            r_c_dir        <= n_c_dir;
        end
    end

endmodule
`default_nettype wire
